>>> hw/rtl/nsfc_pkg.sv
// Package for the NMEA sentence framer and checksum checker.
// Holds the character constants, the status and type codes, the result struct
// and the small decode functions. It depends on nothing else.
`default_nettype none

package nsfc_pkg;

    // Default depth of the line buffer, counted in bytes.
    localparam int unsigned LINE_BYTES_DEF = 128;

    // Longest line that can still be reported as valid.
    localparam int unsigned LEN_LIMIT = 200;

    // Width of the reported line length.
    localparam int unsigned LEN_W = 7;

    // Characters that frame a sentence.
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Sentence type letters, first letter in the top byte.
    localparam logic [23:0] LETTERS_RMC = 24'h524D43;
    localparam logic [23:0] LETTERS_GGA = 24'h474741;
    localparam logic [23:0] LETTERS_GSA = 24'h475341;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_BAD_CHECK = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_RMC  = 2'd0,
        KIND_GGA  = 2'd1,
        KIND_GSA  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // Where the checksum field parse stands within a line.
    typedef enum logic [2:0] {
        PH_BEFORE_STAR = 3'd0,
        PH_DIGIT1      = 3'd1,
        PH_DIGIT2      = 3'd2,
        PH_DONE        = 3'd3,
        PH_BAD         = 3'd4
    } phase_t;

    // One result item.
    typedef struct packed {
        status_t       line_status;
        kind_t         sentence_type;
        logic [LEN_W-1:0] line_length;
        logic [7:0]    computed_checksum;
    } result_t;

    // Registered input byte handed to the checker.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } stage_t;

    // Result pushed from the checker into the output queue.
    typedef struct packed {
        logic    valid;
        result_t payload;
    } push_t;

    // Bit 4 flags a hex digit; bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // Maps the three type letters to a sentence type code.
    function automatic kind_t decode_kind(input logic [23:0] letters);
        kind_t k;
        if (letters == LETTERS_RMC) begin
            k = KIND_RMC;
        end
        else if (letters == LETTERS_GGA) begin
            k = KIND_GGA;
        end
        else if (letters == LETTERS_GSA) begin
            k = KIND_GSA;
        end
        else begin
            k = KIND_NONE;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nsfc_if.sv
// Handshake channels of the NMEA sentence framer and checksum checker.
// One interface carries received bytes, the other carries line results.
// Neither depends on the package.
`default_nettype none

interface nsfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsfc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] line_status;
    logic [1:0] sentence_type;
    logic [6:0] line_length;
    logic [7:0] computed_checksum;

    modport source (
        output valid, output line_status, output sentence_type,
        output line_length, output computed_checksum, input ready
    );
    modport sink (
        input valid, input line_status, input sentence_type,
        input line_length, input computed_checksum, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/nsfc_in_stage.sv
// Input register of the NMEA sentence framer and checksum checker.
// Captures one byte per cycle unless stalled. Uses nsfc_pkg and nsfc_byte_if.
`default_nettype none

module nsfc_in_stage
    import nsfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    nsfc_byte_if.sink    rx,
    input  logic         take,
    output stage_t       stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    // The register frees up in the same cycle that the checker takes its byte.
    assign rx.ready = !valid_reg || take;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = (valid_reg && !take) || accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Byte payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/nsfc_checker.sv
// Line framing and checksum logic of the NMEA sentence framer and checksum checker.
// Holds the per-line state and turns one byte per cycle into an optional result
// while the output queue has room. Uses nsfc_pkg.
`default_nettype none

module nsfc_checker
    import nsfc_pkg::*;
#(
    parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  stage_t stage,
    input  logic   room,
    output logic   take,
    output push_t  push
);

    localparam int unsigned POS_W   = $clog2(LINE_BYTES);
    localparam int unsigned CMP_W   = 9;
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(LINE_BYTES - 1);

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       prev_reg;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [7:0]       rcv_reg;
    logic [7:0]       rcv_next;
    logic             start_reg;
    logic             start_next;
    logic [23:0]      letters_reg;
    logic [23:0]      letters_next;

    logic [7:0]       b;
    logic [4:0]       digit;
    logic [POS_W-1:0] pos_inc;
    logic             line_end;
    logic             full;
    logic             emit;
    logic             len_ok;
    kind_t            kind;
    status_t          status;

    assign take  = stage.valid && room;
    assign b     = stage.data;
    assign digit = hex_digit(b);

    // Checksum field parse: next phase, running XOR and received digits.
    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        rcv_next   = rcv_reg;
        start_next = start_reg;
        if (pos_reg == '0)
        begin
            start_next = (b == CH_START);
        end
        else
        begin
            unique case (phase_reg)
                PH_BEFORE_STAR:
                begin
                    if (b == CH_STAR)
                    begin
                        phase_next = PH_DIGIT1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ b;
                    end
                end
                PH_DIGIT1, PH_DIGIT2:
                begin
                    if (!digit[4])
                    begin
                        phase_next = PH_BAD;
                    end
                    else
                    begin
                        rcv_next   = {rcv_reg[3:0], digit[3:0]};
                        phase_next = (phase_reg == PH_DIGIT1) ? PH_DIGIT2 : PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    if (digit[4])
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_BAD:
                begin
                    phase_next = PH_BAD;
                end
                default:
                begin
                    phase_next = PH_BAD;
                end
            endcase
        end
    end

    // Type letters sit at byte positions three to five.
    always_comb
    begin
        letters_next = letters_reg;
        if (pos_reg == POS_W'(3))
        begin
            letters_next[23:16] = b;
        end
        else if (pos_reg == POS_W'(4))
        begin
            letters_next[15:8] = b;
        end
        else if (pos_reg == POS_W'(5))
        begin
            letters_next[7:0] = b;
        end
    end

    // Line end, buffer full and the status of the line.
    always_comb
    begin
        pos_inc  = pos_reg + POS_W'(1);
        line_end = (b == CH_LF) && (prev_reg == CH_CR);
        full     = (pos_inc == POS_FULL);
        emit     = line_end || full;
        len_ok   = CMP_W'(pos_inc) <= CMP_W'(LEN_LIMIT);
        kind     = decode_kind(letters_next);
        if (!line_end)
        begin
            status = ST_OVERFLOW;
        end
        else if (kind == KIND_NONE)
        begin
            status = ST_BAD_TYPE;
        end
        else if (start_next && phase_next == PH_DONE && rcv_next == xor_next && len_ok)
        begin
            status = ST_VALID;
        end
        else
        begin
            status = ST_BAD_CHECK;
        end
    end

    // Result handed to the output queue.
    always_comb
    begin
        push.valid                     = take && emit;
        push.payload.line_status       = status;
        push.payload.sentence_type     = kind;
        push.payload.line_length       = LEN_W'(pos_inc);
        push.payload.computed_checksum = xor_next;
    end

    // Line state clears after every result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            prev_reg    <= '0;
            xor_reg     <= '0;
            phase_reg   <= PH_BEFORE_STAR;
            rcv_reg     <= '0;
            start_reg   <= 1'b0;
            letters_reg <= '0;
        end
        else if (take)
        begin
            if (emit)
            begin
                pos_reg     <= '0;
                prev_reg    <= '0;
                xor_reg     <= '0;
                phase_reg   <= PH_BEFORE_STAR;
                rcv_reg     <= '0;
                start_reg   <= 1'b0;
                letters_reg <= '0;
            end
            else
            begin
                pos_reg     <= pos_inc;
                prev_reg    <= b;
                xor_reg     <= xor_next;
                phase_reg   <= phase_next;
                rcv_reg     <= rcv_next;
                start_reg   <= start_next;
                letters_reg <= letters_next;
            end
        end
    end

    // A result always restarts framing at position zero.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> (pos_reg == '0 && prev_reg == '0))
        else $error("line state not cleared after a result");

    // The position never reaches the buffer-full mark in stored state.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != POS_FULL)
        else $error("byte position passed the buffer-full mark");

    // The checksum parse only leaves its first phase after a star at position one or later.
    a_phase_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BEFORE_STAR) |-> (pos_reg >= POS_W'(2)))
        else $error("checksum phase advanced too early in the line");

endmodule

`default_nettype wire

>>> hw/rtl/nsfc_out_queue.sv
// Two-entry output queue of the NMEA sentence framer and checksum checker.
// Decouples the result channel from the checker. Uses nsfc_pkg and nsfc_result_if.
`default_nettype none

module nsfc_out_queue
    import nsfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    output logic          room,
    nsfc_result_if.source res
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;
    logic       push_head;

    assign room = (count_reg != 2'd2);
    assign pop  = (count_reg != 2'd0) && res.ready;

    // A new item lands in the head when the queue is empty after this cycle's pop.
    assign push_head = push.valid && (count_reg == 2'd0 || (count_reg == 2'd1 && pop));

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entry shifting: the head is always the oldest item.
    always_ff @(posedge clk)
    begin
        if (push_head)
        begin
            head_reg <= push.payload;
        end
        else
        begin
            if (pop)
            begin
                head_reg <= tail_reg;
            end
            if (push.valid)
            begin
                tail_reg <= push.payload;
            end
        end
    end

    assign res.valid             = (count_reg != 2'd0);
    assign res.line_status       = head_reg.line_status;
    assign res.sentence_type     = head_reg.sentence_type;
    assign res.line_length       = head_reg.line_length;
    assign res.computed_checksum = head_reg.computed_checksum;

    // The checker never pushes into a full queue.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (count_reg != 2'd2))
        else $error("result pushed into a full queue");

    // The fill count stays within the two entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue fill count out of range");

    // An item taken with nothing new arriving lowers the fill count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.valid) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue fill count wrong after a pop");

endmodule

`default_nettype wire

>>> hw/rtl/nmea_sentence_framer_checker.sv
// NMEA sentence framer and checksum checker: takes one received byte per cycle
// and gives one result item for each line ended by CR LF, or for a line that fills
// the LINE_BYTES buffer (reported as overflow, after which framing restarts). A byte
// is taken every cycle while the output queue has room; its result, if any, passes
// from the input register through the single-pass checker into a two-entry output
// queue. The checker's per-line state update sets that one-byte-per-cycle rate; a
// stalled result side holds up input only once the queue has two items waiting.
// Uses nsfc_pkg, nsfc_if, nsfc_in_stage, nsfc_checker and nsfc_out_queue.
`default_nettype none

module nmea_sentence_framer_checker
    import nsfc_pkg::*;
#(
    parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    nsfc_byte_if.sink     rx,
    nsfc_result_if.source res
);

    stage_t stage;
    push_t  push;
    logic   take;
    logic   room;

    // Input byte register.
    nsfc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .stage (stage)
    );

    // Framing, type decode and checksum check.
    nsfc_checker #(
        .LINE_BYTES (LINE_BYTES)
    ) u_checker (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .room  (room),
        .take  (take),
        .push  (push)
    );

    // Result queue toward the consumer.
    nsfc_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .res   (res)
    );

endmodule

`default_nettype wire
